>>> sv/jhtb_pkg.sv
package jhtb_pkg;

    // Tree store geometry: entries are kept in pairs, one pair per row
    localparam int TREE_ENTRIES = 8192;
    localparam int TREE_ROWS    = TREE_ENTRIES / 2;
    localparam int ROW_W        = $clog2(TREE_ROWS);
    localparam int FILL_W       = ROW_W + 1;

    // Field and counter widths
    localparam int ENTRY_W   = 14;
    localparam int USED_W    = 14;
    localparam int BYTES_W   = 13;
    localparam int SYMS_W    = 12;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 5;
    localparam int LEVEL_W   = 4;
    localparam int LEN_COUNT = 16;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef entry_t [1:0] row_t;

    localparam entry_t ENTRY_EMPTY = -14'sd1;

    // Commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_COMPLETE = 3'd1;
    localparam logic [2:0] STAT_SHORT    = 3'd2;
    localparam logic [2:0] STAT_OVERFLOW = 3'd3;
    localparam logic [2:0] STAT_FULL     = 3'd4;
    localparam logic [2:0] STAT_IGNORED  = 3'd5;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LENGTHS,
        PH_SYMBOLS
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_BYTE,
        ST_WALK,
        ST_SEEK,
        ST_OUT
    } state_t;

    // Access request to the tree store
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        row_t             wr_data;
        logic             clear;
        logic             alloc;
    } store_req_t;

endpackage

>>> sv/jhtb_tree_store.sv
module jhtb_tree_store (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jhtb_pkg::store_req_t       req,
    input  logic [jhtb_pkg::FILL_W-1:0] fill_rows,
    output jhtb_pkg::row_t             rd_data
);
    import jhtb_pkg::*;

    row_t             mem [TREE_ROWS];
    row_t             rd_data_reg;
    logic [ROW_W-1:0] rd_row_reg;
    logic             top_fresh_reg;
    logic             top_fresh_next;
    logic [FILL_W-1:0] top_row;
    logic             rd_fresh;

    // Single write port, single registered read port
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_row] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_row];
            rd_row_reg  <= req.rd_row;
        end
    end

    // Rows at or above the fill mark, and the newest row until first written, read as empty
    assign top_row = fill_rows - FILL_W'(1);

    always_comb begin
        top_fresh_next = top_fresh_reg;
        if (req.clear || req.alloc) begin
            top_fresh_next = 1'b1;
        end else if (req.wr_en && ({1'b0, req.wr_row} == top_row)) begin
            top_fresh_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_fresh_reg <= 1'b1;
        end else begin
            top_fresh_reg <= top_fresh_next;
        end
    end

    assign rd_fresh = ({1'b0, rd_row_reg} >= fill_rows) ||
                      (top_fresh_reg && ({1'b0, rd_row_reg} == top_row));
    assign rd_data  = rd_fresh ? {ENTRY_EMPTY, ENTRY_EMPTY} : rd_data_reg;

endmodule

>>> sv/jpeg_huffman_tree_builder_unit.sv
// Builds a binary Huffman decode tree from the bytes of one JPEG DHT table, fed one byte per
// transaction (16 length counts, then symbols), and reads tree entries back on command. One
// transaction at a time is in work; every transaction gives one result. A tree read reads the
// store, then presents the entry; a length count byte is stored, and the sixteenth one, unless
// no symbols are counted, is followed by a search for the first used length; a symbol byte
// walks the tree from the root to the level of its code length and places its leaf, then
// searches for the next code length with symbols left, unless it completes the table or fails.
// The tree store is a single memory of entry pairs with one write port and one registered read
// port, and the walk reads one tree level per cycle, writing back the parent pair whenever it
// allocates a child pair. A new table (table_start) clears the tree in the accept cycle: pairs
// above the allocation mark read as empty, so no clearing pass is run after reset or table
// start.
module jpeg_huffman_tree_builder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic [7:0]                        s_table_byte,
    input  logic                              s_table_start,
    input  logic                              s_segment_end,
    input  logic [12:0]                       s_entry_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [2:0]                        m_status,
    output jhtb_pkg::entry_t                  m_entry_value,
    output logic [jhtb_pkg::USED_W-1:0]       m_entries_used,
    output logic [jhtb_pkg::BYTES_W-1:0]      m_bytes_consumed
);
    import jhtb_pkg::*;

    // Control state
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           counts_reg [LEN_COUNT];
    logic [7:0]           counts_next [LEN_COUNT];
    logic [BYTES_W-1:0]   bc_reg, bc_next;
    logic [SYMS_W-1:0]    sl_reg, sl_next;
    logic [CODE_W-1:0]    code_reg, code_next;
    logic [LEN_W-1:0]     cl_reg, cl_next;
    logic [7:0]           lil_reg, lil_next;
    logic [USED_W-1:0]    nfe_reg, nfe_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 m_valid_reg, m_valid_next;

    // Payload
    logic [7:0]           byte_reg, byte_next;
    logic                 seg_reg, seg_next;
    logic [12:0]          idx_reg, idx_next;
    logic [2:0]           res_status_reg, res_status_next;
    entry_t               res_value_reg, res_value_next;
    logic [2:0]           m_status_reg, m_status_next;
    entry_t               m_value_reg, m_value_next;
    logic [USED_W-1:0]    m_used_reg, m_used_next;
    logic [BYTES_W-1:0]   m_bytes_reg, m_bytes_next;

    // Store interface and walk temporaries
    store_req_t           req;
    row_t                 rd_data;
    row_t                 row_mod;
    logic                 cur_bit;
    entry_t               v;
    logic [ENTRY_W-1:0]   child_idx;
    logic [CODE_W-1:0]    step;
    logic [CODE_W:0]      code_sum;
    logic [SYMS_W-1:0]    sl_sum;
    logic [LEN_W-1:0]     cl_inc;

    jhtb_tree_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .fill_rows (nfe_reg[USED_W-1:1]),
        .rd_data   (rd_data)
    );

    // Next state and outputs
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        counts_next     = counts_reg;
        bc_next         = bc_reg;
        sl_next         = sl_reg;
        code_next       = code_reg;
        cl_next         = cl_reg;
        lil_next        = lil_reg;
        nfe_next        = nfe_reg;
        level_next      = level_reg;
        row_next        = row_reg;
        byte_next       = byte_reg;
        seg_next        = seg_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_used_next     = m_used_reg;
        m_bytes_next    = m_bytes_reg;
        req             = '0;
        s_ready         = 1'b0;
        row_mod         = rd_data;
        cur_bit         = code_reg[4'(CODE_W - 1) - level_reg];
        v               = rd_data[cur_bit];
        child_idx       = ~v + 1'b1;
        step            = 16'h8000 >> cl_reg[LEVEL_W-1:0];
        code_sum        = {1'b0, code_reg} + {1'b0, step};
        sl_sum          = sl_reg + SYMS_W'(byte_reg);
        cl_inc          = cl_reg + LEN_W'(1);

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    byte_next = s_table_byte;
                    seg_next  = s_segment_end;
                    idx_next  = s_entry_index;
                    if (s_command == CMD_READ) begin
                        req.rd_en  = 1'b1;
                        req.rd_row = s_entry_index[ROW_W:1];
                        state_next = ST_READ;
                    end else begin
                        // new table: drop the tree and all counters
                        if (s_table_start) begin
                            phase_next  = PH_LENGTHS;
                            counts_next = '{default: '0};
                            bc_next     = '0;
                            sl_next     = '0;
                            code_next   = '0;
                            cl_next     = '0;
                            lil_next    = '0;
                            nfe_next    = USED_W'(2);
                            req.clear   = 1'b1;
                        end
                        state_next = ST_BYTE;
                    end
                end
            end

            ST_READ: begin
                if (32'(idx_reg) < TREE_ENTRIES) begin
                    res_status_next = STAT_OK;
                    res_value_next  = rd_data[idx_reg[0]];
                end else begin
                    res_status_next = STAT_IGNORED;
                    res_value_next  = ENTRY_EMPTY;
                end
                state_next = ST_OUT;
            end

            ST_BYTE: begin
                res_value_next = '0;
                if (phase_reg == PH_IDLE) begin
                    res_status_next = STAT_IGNORED;
                    state_next      = ST_OUT;
                end else begin
                    bc_next = bc_reg + BYTES_W'(1);
                    if (phase_reg == PH_LENGTHS) begin
                        counts_next[bc_reg[3:0]] = byte_reg;
                        sl_next = sl_sum;
                        if (bc_reg < BYTES_W'(LEN_COUNT - 1)) begin
                            res_status_next = seg_reg ? STAT_SHORT : STAT_OK;
                            if (seg_reg) begin
                                phase_next = PH_IDLE;
                            end
                            state_next = ST_OUT;
                        end else if (sl_sum == '0) begin
                            res_status_next = STAT_COMPLETE;
                            phase_next      = PH_IDLE;
                            state_next      = ST_OUT;
                        end else begin
                            // counts done: find the first length in use
                            phase_next      = seg_reg ? PH_IDLE : PH_SYMBOLS;
                            cl_next         = '0;
                            lil_next        = counts_reg[0];
                            res_status_next = seg_reg ? STAT_SHORT : STAT_OK;
                            state_next      = ST_SEEK;
                        end
                    end else begin
                        // symbol: start the walk at the root pair
                        level_next = '0;
                        row_next   = '0;
                        req.rd_en  = 1'b1;
                        req.rd_row = '0;
                        state_next = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                if (level_reg != cl_reg[LEVEL_W-1:0]) begin
                    // inner level: follow or allocate a child pair
                    if (v == ENTRY_EMPTY) begin
                        if (32'(nfe_reg) + 2 > TREE_ENTRIES) begin
                            res_status_next = STAT_FULL;
                            phase_next      = PH_IDLE;
                            state_next      = ST_OUT;
                        end else begin
                            row_mod[cur_bit] = entry_t'(~nfe_reg + 1'b1);
                            req.wr_en   = 1'b1;
                            req.wr_row  = row_reg;
                            req.wr_data = row_mod;
                            req.alloc   = 1'b1;
                            nfe_next    = nfe_reg + USED_W'(2);
                            row_next    = nfe_reg[ROW_W:1];
                            req.rd_en   = 1'b1;
                            req.rd_row  = nfe_reg[ROW_W:1];
                            level_next  = level_reg + LEVEL_W'(1);
                        end
                    end else if (!v[ENTRY_W-1]) begin
                        res_status_next = STAT_OVERFLOW;
                        phase_next      = PH_IDLE;
                        state_next      = ST_OUT;
                    end else if (32'(child_idx) + 1 >= TREE_ENTRIES) begin
                        res_status_next = STAT_FULL;
                        phase_next      = PH_IDLE;
                        state_next      = ST_OUT;
                    end else begin
                        row_next   = child_idx[ROW_W:1];
                        req.rd_en  = 1'b1;
                        req.rd_row = child_idx[ROW_W:1];
                        level_next = level_reg + LEVEL_W'(1);
                    end
                end else begin
                    // last level: place the leaf, then advance the code
                    if (v != ENTRY_EMPTY) begin
                        res_status_next = STAT_OVERFLOW;
                        phase_next      = PH_IDLE;
                        state_next      = ST_OUT;
                    end else begin
                        row_mod[cur_bit] = entry_t'({{(ENTRY_W - 8){1'b0}}, byte_reg});
                        req.wr_en   = 1'b1;
                        req.wr_row  = row_reg;
                        req.wr_data = row_mod;
                        if (code_sum[CODE_W]) begin
                            res_status_next = STAT_OVERFLOW;
                            phase_next      = PH_IDLE;
                            state_next      = ST_OUT;
                        end else begin
                            code_next = code_sum[CODE_W-1:0];
                            sl_next   = sl_reg - SYMS_W'(1);
                            lil_next  = lil_reg - 8'd1;
                            if (sl_reg == SYMS_W'(1)) begin
                                res_status_next = STAT_COMPLETE;
                                phase_next      = PH_IDLE;
                                state_next      = ST_OUT;
                            end else begin
                                res_status_next = seg_reg ? STAT_SHORT : STAT_OK;
                                if (seg_reg) begin
                                    phase_next = PH_IDLE;
                                end
                                state_next = ST_SEEK;
                            end
                        end
                    end
                end
            end

            ST_SEEK: begin
                // one code length per cycle until one with symbols left
                if ((cl_reg < LEN_W'(LEN_COUNT)) && (lil_reg == '0)) begin
                    cl_next = cl_inc;
                    if (cl_reg < LEN_W'(LEN_COUNT - 1)) begin
                        lil_next = counts_reg[cl_inc[LEVEL_W-1:0]];
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_used_next   = nfe_reg;
                    m_bytes_next  = bc_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_IDLE;
            counts_reg  <= '{default: '0};
            bc_reg      <= '0;
            sl_reg      <= '0;
            code_reg    <= '0;
            cl_reg      <= '0;
            lil_reg     <= '0;
            nfe_reg     <= USED_W'(2);
            level_reg   <= '0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            counts_reg  <= counts_next;
            bc_reg      <= bc_next;
            sl_reg      <= sl_next;
            code_reg    <= code_next;
            cl_reg      <= cl_next;
            lil_reg     <= lil_next;
            nfe_reg     <= nfe_next;
            level_reg   <= level_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        byte_reg       <= byte_next;
        seg_reg        <= seg_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_used_reg     <= m_used_next;
        m_bytes_reg    <= m_bytes_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_entry_value    = m_value_reg;
    assign m_entries_used   = m_used_reg;
    assign m_bytes_consumed = m_bytes_reg;

endmodule
